// ===== rtl/egcd_pkg.sv =====
// egcd_pkg: shared constants and controller/datapath interface types
// for the gcd unit. No dependencies.

package egcd_pkg;

  localparam int unsigned DataWidthDefault = 32;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture operand magnitudes, clear the shift count
    logic step;  // one binary gcd reduction step
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic equal;  // working values match, result is ready
  } dp_status_t;

endpackage

// ===== rtl/egcd_datapath.sv =====
// egcd_datapath: operand magnitudes, working registers and one
// subtract/shift reduction step per cycle while step is set. Depends on egcd_pkg.

module egcd_datapath #(
  parameter int unsigned DATA_WIDTH = egcd_pkg::DataWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  egcd_pkg::dp_cmd_t            cmd_i,
  output egcd_pkg::dp_status_t         status_o,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic        [DATA_WIDTH-1:0] divisor_o,
  output logic                         undefined_o
);

  localparam int unsigned KW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] raw_a, raw_b, mag_a, mag_b;
  logic [DATA_WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0]         k_q, k_d;
  logic                  undef_q, undef_d;
  logic                  a_gt_b;
  logic [DATA_WIDTH-1:0] diff;

  assign raw_a = $unsigned(operand_a_i);
  assign raw_b = $unsigned(operand_b_i);
  // most negative value wraps to 2^(W-1), which fits unsigned
  assign mag_a = raw_a[DATA_WIDTH-1] ? (~raw_a + 1'b1) : raw_a;
  assign mag_b = raw_b[DATA_WIDTH-1] ? (~raw_b + 1'b1) : raw_b;

  assign a_gt_b = a_q > b_q;
  assign diff   = a_gt_b ? (a_q - b_q) : (b_q - a_q);

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    undef_d = undef_q;
    if (cmd_i.load) begin
      k_d     = '0;
      undef_d = (mag_a == '0) && (mag_b == '0);
      // a zero operand: both registers take the other magnitude
      if (mag_a == '0) begin
        a_d = mag_b;
        b_d = mag_b;
      end else if (mag_b == '0) begin
        a_d = mag_a;
        b_d = mag_a;
      end else begin
        a_d = mag_a;
        b_d = mag_b;
      end
    end else if (cmd_i.step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_gt_b) begin
        // difference of two odd values is even
        a_d = diff >> 1;
      end else begin
        b_d = diff >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    k_q     <= k_d;
    undef_q <= undef_d;
  end

  assign status_o.equal = (a_q == b_q);
  assign divisor_o      = a_q << k_q;
  assign undefined_o    = undef_q;

  // a step never runs on a zero working value
  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (a_q != '0) && (b_q != '0))
    else $error("gcd step on zero operand");

  // shift count cannot reach the top bit while reduction continues
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !a_q[0] && !b_q[0]) |-> (k_q < KW'(DATA_WIDTH - 1)))
    else $error("gcd shift count overflow");

  // controller only steps while values differ
  a_step_unequal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !status_o.equal)
    else $error("gcd step after convergence");

endmodule

// ===== rtl/egcd_ctrl.sv =====
// egcd_ctrl: handshake and sequencing state machine for the gcd unit.
// Depends on egcd_pkg.

module egcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output egcd_pkg::dp_cmd_t    cmd_o,
  input  egcd_pkg::dp_status_t status_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_accept;

  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_DONE) && out_ready_i);
  assign out_valid_o = (state_q == S_DONE);
  assign in_accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = in_accept;
    cmd_o.step = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_RUN;
      end
      S_RUN: begin
        if (status_i.equal) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_DONE: begin
        // result taken; a waiting transaction starts right away
        if (out_ready_i) state_d = in_accept ? S_RUN : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_RUN))
    else $error("accepted transaction did not start");

  a_converge_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RUN) && status_i.equal) |=> out_valid_o)
    else $error("converged result not presented");

  a_load_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.step))
    else $error("load and step issued together");

endmodule

// ===== rtl/euclid_gcd_unit_top.sv =====
// euclid_gcd_unit_top: greatest common divisor of two signed operands.
// Depends on egcd_pkg, egcd_ctrl and egcd_datapath.

// Takes two signed DATA_WIDTH-bit operands and returns the gcd of their
// magnitudes (the most negative value counts as 2^(DATA_WIDTH-1)). One
// zero operand gives the other magnitude; two zeros give 0 with undefined
// set. The gcd is computed with a binary reduction: each cycle of the run
// phase the shared compare/subtract/shift step either halves even values or
// replaces the larger odd value by half the difference. A transaction runs
// through a load, the reduction steps, the detection that the working
// values have converged and the presentation of the result until it is
// taken. Each step drops at least one bit from the two working values, so
// there are at most 2*DATA_WIDTH-3 steps (fewer for typical data). One
// transaction is in flight at a time. A new transaction is accepted in the
// cycle the previous result is taken.

module euclid_gcd_unit_top #(
  parameter int unsigned DATA_WIDTH = egcd_pkg::DataWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic        [DATA_WIDTH-1:0] divisor_o,
  output logic                         undefined_o
);

  egcd_pkg::dp_cmd_t    cmd;
  egcd_pkg::dp_status_t status;

  egcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  egcd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .divisor_o   (divisor_o),
    .undefined_o (undefined_o)
  );

endmodule

// ===== dv/tb_euclid_gcd_unit_top.sv =====
// tb_euclid_gcd_unit_top: self-checking testbench for the gcd unit, with
// directed, random and back-to-back operand streams checked against a local gcd predictor.
// Depends on egcd_pkg and euclid_gcd_unit_top.

`timescale 1ns / 1ps

module tb_euclid_gcd_unit_top;

  localparam int unsigned DataWidth  = egcd_pkg::DataWidthDefault;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 150;

  typedef logic signed [DataWidth-1:0] operand_t;
  typedef logic        [DataWidth-1:0] magnitude_t;

  typedef struct packed {
    magnitude_t divisor;
    logic       undefined;
  } gcd_result_t;

  localparam operand_t MostNegative = {1'b1, {(DataWidth-1){1'b0}}};
  localparam operand_t MostPositive = {1'b0, {(DataWidth-1){1'b1}}};

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  operand_t   operand_a_i;
  operand_t   operand_b_i;
  logic       out_valid_o;
  logic       out_ready_i;
  magnitude_t divisor_o;
  logic       undefined_o;

  gcd_result_t gcd_expected_q[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          steady_flow;

  euclid_gcd_unit_top #(
    .DATA_WIDTH(DataWidth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .divisor_o  (divisor_o),
    .undefined_o(undefined_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // magnitudes are unsigned, so the most negative operand maps to 2^(w-1)
  function automatic gcd_result_t predict_gcd(operand_t a, operand_t b);
    magnitude_t  x;
    magnitude_t  y;
    magnitude_t  r;
    gcd_result_t res;
    x = a[DataWidth-1] ? magnitude_t'(-a) : magnitude_t'(a);
    y = b[DataWidth-1] ? magnitude_t'(-b) : magnitude_t'(b);
    res.undefined = (x == '0) && (y == '0);
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    res.divisor = x;
    return res;
  endfunction

  function automatic operand_t random_sign(magnitude_t m);
    return ($urandom_range(0, 1) != 0) ? operand_t'(-m) : operand_t'(m);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_operands(operand_t a, operand_t b);
    while (!steady_flow && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // operand pairs of several shapes, full range being only a part of them
  task automatic send_random_pair();
    magnitude_t common;
    longint     fib_lo;
    longint     fib_hi;
    longint     fib_next;
    int         steps;
    case ($urandom_range(0, 9))
      0, 1, 2: send_operands(operand_t'($urandom), operand_t'($urandom));
      3, 4: send_operands(random_sign($urandom_range(0, 1000)),
                          random_sign($urandom_range(0, 1000)));
      5, 6: begin
        common = $urandom_range(1, 65535);
        send_operands(random_sign(common * $urandom_range(0, 32767)),
                      random_sign(common * $urandom_range(1, 32767)));
      end
      7: begin
        // consecutive fibonacci numbers take the most remainder steps
        fib_lo = 1;
        fib_hi = 1;
        steps  = $urandom_range(1, 44);
        repeat (steps) begin
          fib_next = fib_lo + fib_hi;
          fib_lo   = fib_hi;
          fib_hi   = fib_next;
        end
        send_operands(random_sign(magnitude_t'(fib_hi)), random_sign(magnitude_t'(fib_lo)));
      end
      8: begin
        common = magnitude_t'(1) << $urandom_range(0, DataWidth-1);
        send_operands(random_sign(common), operand_t'($urandom));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: send_operands('0, operand_t'($urandom));
          1: send_operands(operand_t'($urandom), '0);
          2: send_operands(MostNegative, operand_t'($urandom));
          default: send_operands(operand_t'($urandom), MostNegative);
        endcase
      end
    endcase
  endtask

  task automatic test_directed();
    send_operands('0, '0);
    send_operands('0, 5);
    send_operands(-7, '0);
    send_operands('0, -1);
    send_operands(-1, '0);
    send_operands('0, MostNegative);
    send_operands(MostNegative, '0);
    send_operands(MostNegative, MostNegative);
    send_operands(MostPositive, MostPositive);
    send_operands(MostNegative, MostPositive);
    send_operands(MostPositive, MostNegative);
    send_operands(1, 1);
    send_operands(-1, -1);
    send_operands(1, MostNegative);
    send_operands(MostNegative, -(1 <<< 30));
    send_operands(MostNegative, 6);
    send_operands(12, 18);
    send_operands(-48, 36);
    send_operands(MostPositive, MostPositive - 1);
    send_operands(1836311903, 1134903170);
    send_operands(-1134903170, 1836311903);
    send_operands(65536 * 3, -65536 * 5);
    send_operands(operand_t'(32'h5555_5555), operand_t'(32'hAAAA_AAAA));
  endtask

  task automatic test_random_operands();
    repeat (1450) send_random_pair();
  endtask

  // neither side idles for this stretch
  task automatic test_steady_stream();
    steady_flow = 1'b1;
    repeat (250) send_random_pair();
    steady_flow = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= 6);
  end

  // each accepted transaction pushes its expected result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      gcd_expected_q.push_back(predict_gcd(operand_a_i, operand_b_i));
    end
  end

  always @(posedge clk_i) begin
    gcd_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gcd_expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result divisor=%0d undefined=%0b",
                 $time, divisor_o, undefined_o);
      end else begin
        exp_res = gcd_expected_q.pop_front();
        if (divisor_o !== exp_res.divisor) begin
          mismatch_count++;
          $display("%0t: divisor mismatch expected=%0d actual=%0d",
                   $time, exp_res.divisor, divisor_o);
        end
        if (undefined_o !== exp_res.undefined) begin
          mismatch_count++;
          $display("%0t: undefined mismatch expected=%0b actual=%0b",
                   $time, exp_res.undefined, undefined_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operand_a_i    = '0;
    operand_b_i    = '0;
    out_ready_i    = 1'b0;
    steady_flow    = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_operands();
    test_steady_stream();
    in_valid_i <= 1'b0;

    while (gcd_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (gcd_expected_q.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, gcd_expected_q.size());
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
